### sv/microwire_eeprom_master_unit_assert.svh
// Assertion macros shared by the Microwire EEPROM master unit.
// Expects i_clk and i_rst_n in scope at the point of use.
`ifndef MICROWIRE_EEPROM_MASTER_UNIT_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MWE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mwe_pkg.sv
// Package for the Microwire EEPROM master: sizes, frame constants, codes and types.
// No dependencies; used by every module of the block.
package mwe_pkg;

    // Device organization
    localparam int ADDRESS_BITS = 6;
    localparam int DATA_BITS    = 16;
    localparam int FRAME_BITS   = 3 + ADDRESS_BITS + DATA_BITS;
    localparam int CNT_W        = $clog2(FRAME_BITS + 1);
    localparam int IDX_W        = $clog2(FRAME_BITS);
    localparam int HALF_W       = 16;
    localparam int TICK_W       = 20;

    // Configuration reset values
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(75);
    localparam logic [TICK_W-1:0] WAIT_RESET = TICK_W'(11000);

    // Configuration register indexes
    localparam logic CFG_HALF = 1'b0;
    localparam logic CFG_WAIT = 1'b1;

    // Command codes
    localparam logic [1:0] OP_WREN  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Frame headers: start bit and opcode
    localparam logic [2:0] HDR_WRITE = 3'b101;
    localparam logic [2:0] HDR_READ  = 3'b110;

    // Write enable: 1 00 11 followed by zeros
    localparam logic [FRAME_BITS-1:0] WREN_FRAME =
        FRAME_BITS'((4 << ADDRESS_BITS) | (3 << (ADDRESS_BITS - 2)));
    localparam logic [CNT_W-1:0] WREN_LEN = CNT_W'(3 + ADDRESS_BITS);
    localparam logic [CNT_W-1:0] FULL_LEN = CNT_W'(FRAME_BITS);
    localparam logic [CNT_W-1:0] DATA_LEN = CNT_W'(DATA_BITS);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_WAIT
    } t_phase;

    typedef struct packed {
        logic [HALF_W-1:0] half_period_ticks;
        logic [TICK_W-1:0] write_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic                    start_req;
        logic [1:0]              op;
        logic [ADDRESS_BITS-1:0] word_address;
        logic [DATA_BITS-1:0]    write_data;
        logic                    serial_in;
    } t_in_item;

    typedef struct packed {
        logic                 chip_select;
        logic                 serial_out;
        logic                 serial_clock;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
    } t_result;

endpackage

### sv/mwe_core.sv
// Input register and per-tick command sequencer of the Microwire EEPROM master.
// Depends on mwe_pkg.
module mwe_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mwe_pkg::t_cfg     i_cfg,
    input  logic             i_valid,
    input  mwe_pkg::t_in_item i_item,
    output logic             o_ready,
    input  logic             i_buf_ready,
    output logic             o_valid,
    output mwe_pkg::t_result  o_result
);

    // Input register
    logic              r_in_valid;
    mwe_pkg::t_in_item r_in;

    // Sequencer state
    mwe_pkg::t_phase              r_phase, n_phase;
    logic [mwe_pkg::FRAME_BITS-1:0] r_frame, n_frame;
    logic [mwe_pkg::CNT_W-1:0]      r_bits, n_bits;
    logic [mwe_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic                          r_clk_lvl, n_clk_lvl;
    logic [1:0]                    r_op, n_op;
    logic [mwe_pkg::DATA_BITS-1:0]  r_read_shift, n_read_shift;
    logic [mwe_pkg::DATA_BITS-1:0]  r_held, n_held;
    logic                          n_done;

    logic [mwe_pkg::TICK_W-1:0]     tick_inc;
    logic [mwe_pkg::IDX_W-1:0]      bit_idx;
    logic                          cur_bit;
    logic                          in_frame;
    logic                          advance;

    assign advance = r_in_valid & i_buf_ready;
    assign o_ready = ~r_in_valid | i_buf_ready;
    assign o_valid = r_in_valid;
    assign tick_inc = r_tick + mwe_pkg::TICK_W'(1);

    // Input register: refills in the cycle the held item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
    end

    // Next state of the sequencer
    always_comb begin
        n_phase      = r_phase;
        n_frame      = r_frame;
        n_bits       = r_bits;
        n_tick       = r_tick;
        n_clk_lvl    = r_clk_lvl;
        n_op         = r_op;
        n_read_shift = r_read_shift;
        n_held       = r_held;
        n_done       = 1'b0;
        unique case (r_phase)
            mwe_pkg::PH_IDLE: begin
                if (r_in.start_req && r_in.op != mwe_pkg::OP_NONE) begin
                    n_op      = r_in.op;
                    n_tick    = '0;
                    n_clk_lvl = 1'b0;
                    n_phase   = mwe_pkg::PH_SHIFT;
                    unique case (r_in.op)
                        mwe_pkg::OP_WREN: begin
                            n_frame = mwe_pkg::WREN_FRAME;
                            n_bits  = mwe_pkg::WREN_LEN;
                        end
                        mwe_pkg::OP_WRITE: begin
                            n_frame = {mwe_pkg::HDR_WRITE, r_in.word_address, r_in.write_data};
                            n_bits  = mwe_pkg::FULL_LEN;
                        end
                        mwe_pkg::OP_READ: begin
                            n_frame = {mwe_pkg::HDR_READ, r_in.word_address,
                                       mwe_pkg::DATA_BITS'(0)};
                            n_bits       = mwe_pkg::FULL_LEN;
                            n_read_shift = '0;
                        end
                        default: begin
                            n_phase = mwe_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            mwe_pkg::PH_SHIFT: begin
                n_tick = tick_inc;
                if (tick_inc >= {{(mwe_pkg::TICK_W - mwe_pkg::HALF_W){1'b0}},
                                 i_cfg.half_period_ticks}) begin
                    n_tick = '0;
                    if (!r_clk_lvl) begin
                        n_clk_lvl = 1'b1;
                    end else begin
                        // falling edge: sample read data, retire one bit
                        n_clk_lvl = 1'b0;
                        if (r_op == mwe_pkg::OP_READ && r_bits <= mwe_pkg::DATA_LEN) begin
                            n_read_shift = {r_read_shift[mwe_pkg::DATA_BITS-2:0], r_in.serial_in};
                        end
                        if (r_bits != '0) begin
                            n_bits = r_bits - mwe_pkg::CNT_W'(1);
                        end
                        if (n_bits == '0) begin
                            if (r_op == mwe_pkg::OP_WRITE && i_cfg.write_wait_ticks != '0) begin
                                n_phase = mwe_pkg::PH_WAIT;
                            end else begin
                                n_phase = mwe_pkg::PH_IDLE;
                                n_done  = 1'b1;
                                if (r_op == mwe_pkg::OP_READ) begin
                                    n_held = n_read_shift;
                                end
                            end
                        end
                    end
                end
            end
            mwe_pkg::PH_WAIT: begin
                n_tick = tick_inc;
                if (tick_inc >= i_cfg.write_wait_ticks) begin
                    n_tick  = '0;
                    n_phase = mwe_pkg::PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = mwe_pkg::PH_IDLE;
            end
        endcase
    end

    // Result fields from the updated state
    always_comb begin
        in_frame = (n_phase == mwe_pkg::PH_SHIFT);
        bit_idx  = mwe_pkg::IDX_W'(n_bits - mwe_pkg::CNT_W'(1));
        cur_bit  = (n_bits != '0) ? n_frame[bit_idx] : 1'b0;
        o_result.chip_select  = in_frame;
        o_result.serial_out   = in_frame & cur_bit;
        o_result.serial_clock = in_frame & n_clk_lvl;
        o_result.busy_res     = (n_phase != mwe_pkg::PH_IDLE);
        o_result.done_res     = n_done;
        o_result.read_data    = n_held;
    end

    // State registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mwe_pkg::PH_IDLE;
            r_frame      <= '0;
            r_bits       <= '0;
            r_tick       <= '0;
            r_clk_lvl    <= 1'b0;
            r_op         <= mwe_pkg::OP_WREN;
            r_read_shift <= '0;
            r_held       <= '0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_frame      <= n_frame;
            r_bits       <= n_bits;
            r_tick       <= n_tick;
            r_clk_lvl    <= n_clk_lvl;
            r_op         <= n_op;
            r_read_shift <= n_read_shift;
            r_held       <= n_held;
        end
    end

endmodule

### sv/mwe_out_buf.sv
// Result register with skid stage for the Microwire EEPROM master.
// Depends on mwe_pkg for the result type.
module mwe_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mwe_pkg::t_result i_result,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output mwe_pkg::t_result o_result
);

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    mwe_pkg::t_result r_out, n_out;
    mwe_pkg::t_result r_skid, n_skid;
    logic             push;
    logic             pop;

    // ready depends only on the skid register
    assign o_ready  = ~r_skid_valid;
    assign push     = i_valid & ~r_skid_valid;
    assign pop      = r_out_valid & i_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Next contents of output and skid registers
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = push;
                n_out       = i_result;
            end
        end else if (push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### sv/microwire_eeprom_master_unit.sv
// Microwire x16 EEPROM master: one input item is one tick, one result item per tick.
// Path: mwe_core input register, combinational sequencer update, then mwe_out_buf result register.
// Throughput: one item per cycle unless the mwe_out_buf skid register is full, which stalls the input.
// Reset (i_rst_n low, synchronous): sequencer idle, pipeline and skid empty,
// half period 75 ticks, write wait 11000 ticks. Depends on mwe_pkg, mwe_core,
// mwe_out_buf and microwire_eeprom_master_unit_assert.svh.
module microwire_eeprom_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // Input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: word_address[5:0], write_data[21:6], serial_in[22], zero[23]
    input  logic [23:0] i_s_tdata,
    // tuser: start_req[0], op[2:1]
    input  logic [2:0]  i_s_tuser,
    // Result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: chip_select[0], serial_out[1], serial_clock[2], busy_res[3],
    //        done_res[4], read_data[20:5], zero[23:21]
    output logic [23:0] o_m_tdata
);

    `include "microwire_eeprom_master_unit_assert.svh"

    mwe_pkg::t_cfg     r_cfg;
    mwe_pkg::t_in_item in_item;
    mwe_pkg::t_result  core_result;
    mwe_pkg::t_result  out_result;
    logic              core_valid;
    logic              buf_ready;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= mwe_pkg::HALF_RESET;
            r_cfg.write_wait_ticks  <= mwe_pkg::WAIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mwe_pkg::CFG_HALF: r_cfg.half_period_ticks <= i_cfg_data[15:0];
                mwe_pkg::CFG_WAIT: r_cfg.write_wait_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack input item
    assign in_item.start_req    = i_s_tuser[0];
    assign in_item.op           = i_s_tuser[2:1];
    assign in_item.word_address = i_s_tdata[5:0];
    assign in_item.write_data   = i_s_tdata[21:6];
    assign in_item.serial_in    = i_s_tdata[22];

    mwe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .i_item      (in_item),
        .o_ready     (o_s_tready),
        .i_buf_ready (buf_ready),
        .o_valid     (core_valid),
        .o_result    (core_result)
    );

    mwe_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (core_valid),
        .i_result (core_result),
        .o_ready  (buf_ready),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    // Pack result item
    assign o_m_tdata = {3'b000, out_result.read_data, out_result.done_res,
                        out_result.busy_res, out_result.serial_clock,
                        out_result.serial_out, out_result.chip_select};

    // Input stalls only when a result is waiting at the output
    `MWE_ASSERT_NOW(a_stall_needs_full_out, !o_s_tready, o_m_tvalid, "input stalled with empty output")
    // A completing tick leaves the block idle
    `MWE_ASSERT_NOW(a_done_not_busy, o_m_tvalid && o_m_tdata[4], !o_m_tdata[3], "done while busy")
    // Select only inside a busy command
    `MWE_ASSERT_NOW(a_select_busy, o_m_tvalid && o_m_tdata[0], o_m_tdata[3], "select while idle")
    // Data and clock lines stay low outside a frame
    `MWE_ASSERT_NOW(a_lines_in_frame, o_m_tvalid && (o_m_tdata[1] || o_m_tdata[2]), o_m_tdata[0],
                    "serial lines active outside frame")

endmodule

### test/mwe_line_checker.sv
`timescale 1ns / 100ps
// Line-level checker for the Microwire EEPROM master: predicts select, data, clock, status
// and read word for every tick item and compares each result item. Depends on mwe_pkg.
module mwe_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    // tdata: word_address[5:0], write_data[21:6], serial_in[22], zero[23]
    input  logic [23:0] i_s_tdata,
    // tuser: start_req[0], op[2:1]
    input  logic [2:0]  i_s_tuser,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: chip_select[0], serial_out[1], serial_clock[2], busy_res[3],
    //        done_res[4], read_data[20:5], zero[23:21]
    input  logic [23:0] o_m_tdata,
    output int          o_pending,
    output int          o_fail_count
);

    // Predicted configuration
    logic [mwe_pkg::HALF_W-1:0]     half_ticks;
    logic [mwe_pkg::TICK_W-1:0]     wait_ticks;

    // Predicted sequencer state
    mwe_pkg::t_phase                phase;
    logic [mwe_pkg::FRAME_BITS-1:0] frame_sr;
    logic [mwe_pkg::CNT_W-1:0]      bits_left;
    logic [mwe_pkg::TICK_W-1:0]     tick_cnt;
    logic                           clk_level;
    logic [1:0]                     cur_op;
    logic [mwe_pkg::DATA_BITS-1:0]  rd_shift;
    logic [mwe_pkg::DATA_BITS-1:0]  held_word;

    // Line states expected for accepted tick items, oldest first
    mwe_pkg::t_result               line_states_q[$];
    int                             fails = 0;

    // One tick of the sequencer; returns the lines after the update
    task automatic advance_tick(input mwe_pkg::t_in_item it, output mwe_pkg::t_result res);
        logic done;
        logic in_frame;
        done = 1'b0;
        case (phase)
            mwe_pkg::PH_IDLE: begin
                // op code 3 is dropped and the sequencer stays idle
                if (it.start_req && it.op != mwe_pkg::OP_NONE) begin
                    cur_op = it.op;
                    case (it.op)
                        mwe_pkg::OP_WREN: begin
                            frame_sr  = mwe_pkg::WREN_FRAME;
                            bits_left = mwe_pkg::WREN_LEN;
                        end
                        mwe_pkg::OP_WRITE: begin
                            frame_sr  = {mwe_pkg::HDR_WRITE, it.word_address, it.write_data};
                            bits_left = mwe_pkg::FULL_LEN;
                        end
                        default: begin
                            frame_sr  = {mwe_pkg::HDR_READ, it.word_address,
                                         {mwe_pkg::DATA_BITS{1'b0}}};
                            bits_left = mwe_pkg::FULL_LEN;
                            rd_shift  = '0;
                        end
                    endcase
                    tick_cnt  = '0;
                    clk_level = 1'b0;
                    phase     = mwe_pkg::PH_SHIFT;
                end
            end
            mwe_pkg::PH_SHIFT: begin
                tick_cnt = tick_cnt + 1'b1;
                // a zero half period acts as one tick
                if (tick_cnt >= half_ticks) begin
                    tick_cnt = '0;
                    if (!clk_level) begin
                        clk_level = 1'b1;
                    end else begin
                        // falling edge: sample read data, move to next bit
                        clk_level = 1'b0;
                        if (cur_op == mwe_pkg::OP_READ && bits_left <= mwe_pkg::DATA_LEN)
                            rd_shift = {rd_shift[mwe_pkg::DATA_BITS-2:0], it.serial_in};
                        if (bits_left != '0)
                            bits_left = bits_left - 1'b1;
                        if (bits_left == '0) begin
                            if (cur_op == mwe_pkg::OP_WRITE && wait_ticks != '0) begin
                                phase = mwe_pkg::PH_WAIT;
                            end else begin
                                phase = mwe_pkg::PH_IDLE;
                                done  = 1'b1;
                                if (cur_op == mwe_pkg::OP_READ)
                                    held_word = rd_shift;
                            end
                        end
                    end
                end
            end
            default: begin
                // write cycle wait with select low
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= wait_ticks) begin
                    tick_cnt = '0;
                    phase    = mwe_pkg::PH_IDLE;
                    done     = 1'b1;
                end
            end
        endcase

        in_frame         = (phase == mwe_pkg::PH_SHIFT);
        res.chip_select  = in_frame;
        res.serial_out   = (in_frame && bits_left != '0) ? frame_sr[bits_left - 1'b1] : 1'b0;
        res.serial_clock = in_frame & clk_level;
        res.busy_res     = (phase != mwe_pkg::PH_IDLE);
        res.done_res     = done;
        res.read_data    = held_word;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    // Track config writes, check results, then predict new items
    always @(posedge i_clk) begin : track
        mwe_pkg::t_in_item item;
        mwe_pkg::t_result  want;
        if (!i_rst_n) begin
            half_ticks = mwe_pkg::HALF_RESET;
            wait_ticks = mwe_pkg::WAIT_RESET;
            phase      = mwe_pkg::PH_IDLE;
            frame_sr   = '0;
            bits_left  = '0;
            tick_cnt   = '0;
            clk_level  = 1'b0;
            cur_op     = mwe_pkg::OP_WREN;
            rd_shift   = '0;
            held_word  = '0;
            line_states_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mwe_pkg::CFG_HALF)
                    half_ticks = i_cfg_data[mwe_pkg::HALF_W-1:0];
                else
                    wait_ticks = i_cfg_data[mwe_pkg::TICK_W-1:0];
            end

            if (o_m_tvalid && i_m_tready) begin
                if (line_states_q.size() == 0) begin
                    $display("%0t: result item with nothing expected, expected none actual %h",
                             $time, o_m_tdata);
                    fails++;
                end else begin
                    want = line_states_q.pop_front();
                    compare_field("chip_select", want.chip_select, o_m_tdata[0]);
                    compare_field("serial_out", want.serial_out, o_m_tdata[1]);
                    compare_field("serial_clock", want.serial_clock, o_m_tdata[2]);
                    compare_field("busy_res", want.busy_res, o_m_tdata[3]);
                    compare_field("done_res", want.done_res, o_m_tdata[4]);
                    compare_field("read_data", want.read_data, o_m_tdata[20:5]);
                end
            end

            if (i_s_tvalid && o_s_tready) begin
                item.start_req    = i_s_tuser[0];
                item.op           = i_s_tuser[2:1];
                item.word_address = i_s_tdata[5:0];
                item.write_data   = i_s_tdata[21:6];
                item.serial_in    = i_s_tdata[22];
                advance_tick(item, want);
                line_states_q.push_back(want);
            end
        end
        o_pending    <= line_states_q.size();
        o_fail_count <= fails;
    end

endmodule

### test/microwire_eeprom_master_unit_tb.sv
`timescale 1ns / 100ps
// Top of the Microwire EEPROM master testbench: clock, reset, tick stimulus, config writes
// and the verdict. Depends on mwe_pkg, the block and mwe_line_checker.
module microwire_eeprom_master_unit_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 300000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [19:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [23:0] i_s_tdata   = '0;
    logic [2:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;

    int pending;
    int fail_count;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // config as last written, used to size the tick runs
    int cur_half      = 75;
    int cur_wait      = 11000;

    microwire_eeprom_master_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    mwe_line_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Receiver stalls at random
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // One tick item; serial_in is random on every tick
    task automatic send_tick(input logic start, input logic [1:0] op,
                             input logic [mwe_pkg::ADDRESS_BITS-1:0] addr,
                             input logic [mwe_pkg::DATA_BITS-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, 1'($urandom_range(0, 1)), data, addr};
        i_s_tuser  <= {op, start};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [1:0] pick_op();
        if ($urandom_range(0, 7) == 0)
            return mwe_pkg::OP_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    // Ticks with random content; start_pct sets how often a command is requested
    task automatic run_ticks(input int n, input int start_pct);
        for (int i = 0; i < n; i++)
            send_tick($urandom_range(0, 99) < start_pct, pick_op(),
                      mwe_pkg::ADDRESS_BITS'($urandom), mwe_pkg::DATA_BITS'($urandom));
    endtask

    // Ticks a command needs to finish under the current config
    function automatic int frame_ticks(input logic [1:0] op);
        int h;
        h = (cur_half == 0) ? 1 : cur_half;
        return 2 * h * ((op == mwe_pkg::OP_WREN) ? mwe_pkg::WREN_LEN : mwe_pkg::FULL_LEN)
               + ((op == mwe_pkg::OP_WRITE) ? cur_wait : 0) + 4;
    endfunction

    // Start a command and tick until it is done; with nag, requests keep
    // coming during the first part of the frame and must be ignored
    task automatic issue(input logic [1:0] op, input logic [mwe_pkg::ADDRESS_BITS-1:0] addr,
                         input logic [mwe_pkg::DATA_BITS-1:0] data, input logic nag);
        int n;
        n = frame_ticks(op);
        send_tick(1'b1, op, addr, data);
        for (int i = 0; i < n; i++)
            send_tick(nag && (i < n / 4), pick_op(),
                      mwe_pkg::ADDRESS_BITS'($urandom), mwe_pkg::DATA_BITS'($urandom));
    endtask

    // Quiet ticks until any running command has completed
    task automatic settle();
        run_ticks(frame_ticks(mwe_pkg::OP_WRITE), 0);
    endtask

    // Hold the sender until every expected result item has arrived
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic index, input int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= 20'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == mwe_pkg::CFG_HALF)
            cur_half = value & 16'hFFFF;
        else
            cur_wait = value & 20'hFFFFF;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset levels, then a write enable at the reset timing; the half
        // period is shortened partway through the frame
        run_ticks(4, 0);
        send_tick(1'b1, mwe_pkg::OP_WREN, '0, '0);
        run_ticks(320, 0);

        // Shortest half period, no write wait: done as select drops
        write_reg(mwe_pkg::CFG_HALF, 1);
        write_reg(mwe_pkg::CFG_WAIT, 0);
        run_ticks(frame_ticks(mwe_pkg::OP_WREN), 0);
        issue(mwe_pkg::OP_WRITE, '1, '1, 1'b0);
        issue(mwe_pkg::OP_READ, '0, '0, 1'b1);
        send_tick(1'b1, mwe_pkg::OP_NONE, '1, '1);
        run_ticks(3, 0);
        issue(mwe_pkg::OP_WREN, '1, '0, 1'b1);

        // Zero half period acts as one tick
        write_reg(mwe_pkg::CFG_HALF, 0);
        write_reg(mwe_pkg::CFG_WAIT, 1);
        issue(mwe_pkg::OP_WRITE, '0, '0, 1'b0);
        issue(mwe_pkg::OP_READ, '1, '1, 1'b0);

        write_reg(mwe_pkg::CFG_HALF, 3);
        write_reg(mwe_pkg::CFG_WAIT, 7);
        issue(mwe_pkg::OP_WRITE, 6'h2A, 16'h5A5A, 1'b1);
        issue(mwe_pkg::OP_READ, 6'h15, 16'hA5A5, 1'b0);

        // Largest settings, sequencer left idle
        write_reg(mwe_pkg::CFG_HALF, 16'hFFFF);
        write_reg(mwe_pkg::CFG_WAIT, 20'hFFFFF);
        run_ticks(20, 0);

        // Random: sender idles less than receiver
        write_reg(mwe_pkg::CFG_HALF, 2);
        write_reg(mwe_pkg::CFG_WAIT, 9);
        send_idle_pct = 32;
        recv_idle_pct = 58;
        run_ticks(100, 15);
        wait_drained();
        run_ticks(100, 15);
        settle();

        // Random: receiver idles less than sender
        write_reg(mwe_pkg::CFG_HALF, 1);
        write_reg(mwe_pkg::CFG_WAIT, 0);
        send_idle_pct = 58;
        recv_idle_pct = 32;
        run_ticks(120, 15);
        settle();

        // Random: no idling
        write_reg(mwe_pkg::CFG_HALF, $urandom_range(1, 4));
        write_reg(mwe_pkg::CFG_WAIT, $urandom_range(0, 30));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_ticks(100, 15);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/mwe_pkg.sv
sv/mwe_core.sv
sv/mwe_out_buf.sv
sv/microwire_eeprom_master_unit.sv
test/mwe_line_checker.sv
test/microwire_eeprom_master_unit_tb.sv
